// File: src/exgp_pkg.sv
// shared constants, types and a helper function for the exp-golomb bit packer
package exgp_pkg;

    // field widths of one request, the output byte and the pending bit count
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 26;
    localparam int CNT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = $clog2(BYTE_W);

    // codeword limits
    localparam int ESCAPE_PREFIX = 10;
    localparam int ESCAPE_BITS   = 25;
    localparam int EG_MAX        = 2046;
    localparam int EG_W          = 11;
    localparam int RAW_MAX       = 25;
    localparam int BLEN_W        = 5;

    // escape value range
    localparam int ESC_W = ((ESCAPE_BITS > ESCAPE_PREFIX) ? ESCAPE_BITS : ESCAPE_PREFIX) + 1;
    localparam int CMP_W = (ESC_W > VALUE_W) ? ESC_W : VALUE_W;
    localparam logic [ESC_W-1:0] ESC_HI = (ESCAPE_BITS > ESCAPE_PREFIX)
        ? ESC_W'((64'd1 << ESCAPE_BITS) - 64'd2)
        : ESC_W'((64'd1 << ESCAPE_PREFIX) - 64'd2);

    // codeword and accumulator sizes
    localparam int CODE_A = ESCAPE_PREFIX + ESCAPE_BITS;
    localparam int CODE_B = (2 * ESCAPE_PREFIX) - 1;
    localparam int CODE_C = (VALUE_W > 2 * EG_W) ? VALUE_W : 2 * EG_W;
    localparam int CODE_AB = (CODE_A > CODE_B) ? CODE_A : CODE_B;
    localparam int CODE_W = (CODE_AB > CODE_C) ? CODE_AB : CODE_C;
    localparam int ACC_W  = CODE_W + BYTE_W;
    localparam int LEN_W  = $clog2(ACC_W + 1);

    // queue between encoder and packer
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // kind codes
    localparam logic [KIND_W-1:0] KIND_UNSIGNED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ESCAPE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNARY3   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNARY2   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RAW      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FLUSH    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED   = 3'd7;

    // one classified codeword, left aligned
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              flush;
    } t_code;

    // number of significant bits
    function automatic logic [BLEN_W-1:0] bit_len(input logic [15:0] m);
        logic [BLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (m[i]) begin
                n = BLEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: src/exgp_encoder.sv
// front end: saturates the value and builds the left-aligned codeword
module exgp_encoder (
    input  logic [exgp_pkg::KIND_W-1:0]  i_kind,
    input  logic [exgp_pkg::VALUE_W-1:0] i_value,
    input  logic [exgp_pkg::CNT_W-1:0]   i_bit_count,
    output exgp_pkg::t_code              o_code
);

    logic                               v_neg;
    logic [exgp_pkg::VALUE_W-1:0]       v_abs;
    logic [exgp_pkg::EG_W-1:0]          u_eg;
    logic [exgp_pkg::EG_W-1:0]          mag;
    logic [exgp_pkg::EG_W-1:0]          eg_src;
    logic [exgp_pkg::EG_W-1:0]          m_eg;
    logic [exgp_pkg::BLEN_W-1:0]        n_eg;
    logic [exgp_pkg::CMP_W-1:0]         val_ext;
    logic [exgp_pkg::ESC_W-1:0]         esc_u;
    logic [exgp_pkg::ESC_W-1:0]         m_esc;
    logic                               esc_short;
    logic [exgp_pkg::BLEN_W-1:0]        n_esc;
    logic [1:0]                         u_un3;
    logic [1:0]                         u_un2;
    logic [exgp_pkg::CNT_W-1:0]         raw_cnt;
    logic [exgp_pkg::CODE_W-1:0]        raw_mask;
    logic [exgp_pkg::CODE_W-1:0]        code_r;
    logic [exgp_pkg::LEN_W-1:0]         len_r;
    logic                               flush_r;

    // saturation of the value for each kind
    always_comb begin
        v_neg   = i_value[exgp_pkg::VALUE_W-1];
        v_abs   = v_neg ? (~i_value + 1'b1) : i_value;
        u_eg    = (v_neg) ? '0
                : (i_value > exgp_pkg::VALUE_W'(exgp_pkg::EG_MAX)) ? exgp_pkg::EG_W'(exgp_pkg::EG_MAX)
                : i_value[exgp_pkg::EG_W-1:0];
        mag     = (v_abs > exgp_pkg::VALUE_W'(exgp_pkg::EG_MAX)) ? exgp_pkg::EG_W'(exgp_pkg::EG_MAX)
                : v_abs[exgp_pkg::EG_W-1:0];
        eg_src  = (i_kind == exgp_pkg::KIND_SIGNED) ? mag : u_eg;
        m_eg    = eg_src + 1'b1;
        n_eg    = exgp_pkg::bit_len(16'(m_eg));

        val_ext = exgp_pkg::CMP_W'(i_value[exgp_pkg::VALUE_W-2:0]);
        esc_u   = (v_neg) ? '0
                : (val_ext > exgp_pkg::CMP_W'(exgp_pkg::ESC_HI)) ? exgp_pkg::ESC_HI
                : val_ext[exgp_pkg::ESC_W-1:0];
        m_esc   = esc_u + 1'b1;
        esc_short = m_esc < (exgp_pkg::ESC_W'(1) << exgp_pkg::ESCAPE_PREFIX);
        n_esc   = exgp_pkg::bit_len(16'(m_esc[exgp_pkg::ESCAPE_PREFIX-1:0]));

        u_un3   = (v_neg) ? 2'd0
                : (i_value >= exgp_pkg::VALUE_W'(3)) ? 2'd3 : i_value[1:0];
        u_un2   = (v_neg) ? 2'd0
                : (i_value >= exgp_pkg::VALUE_W'(2)) ? 2'd2 : i_value[1:0];

        raw_cnt  = (i_bit_count > exgp_pkg::CNT_W'(exgp_pkg::RAW_MAX))
                 ? exgp_pkg::CNT_W'(exgp_pkg::RAW_MAX) : i_bit_count;
        raw_mask = (exgp_pkg::CODE_W'(1) << raw_cnt) - 1'b1;
    end

    // right-aligned codeword and its length
    always_comb begin
        code_r  = '0;
        len_r   = '0;
        flush_r = 1'b0;
        unique case (i_kind)
            exgp_pkg::KIND_UNSIGNED: begin
                code_r = exgp_pkg::CODE_W'(m_eg);
                len_r  = exgp_pkg::LEN_W'({n_eg, 1'b0} - 1'b1);
            end
            exgp_pkg::KIND_SIGNED: begin
                if (mag != '0) begin
                    code_r = exgp_pkg::CODE_W'({m_eg, v_neg});
                    len_r  = exgp_pkg::LEN_W'({n_eg, 1'b0});
                end else begin
                    code_r = exgp_pkg::CODE_W'(1);
                    len_r  = exgp_pkg::LEN_W'(1);
                end
            end
            exgp_pkg::KIND_ESCAPE: begin
                code_r = exgp_pkg::CODE_W'(m_esc);
                if (esc_short) begin
                    len_r = exgp_pkg::LEN_W'({n_esc, 1'b0} - 1'b1);
                end else begin
                    len_r = exgp_pkg::LEN_W'(exgp_pkg::ESCAPE_PREFIX + exgp_pkg::ESCAPE_BITS);
                end
            end
            exgp_pkg::KIND_UNARY3: begin
                case (u_un3)
                    2'd0: begin
                        code_r = exgp_pkg::CODE_W'(0);
                        len_r  = exgp_pkg::LEN_W'(1);
                    end
                    2'd1: begin
                        code_r = exgp_pkg::CODE_W'(2);
                        len_r  = exgp_pkg::LEN_W'(2);
                    end
                    2'd2: begin
                        code_r = exgp_pkg::CODE_W'(6);
                        len_r  = exgp_pkg::LEN_W'(3);
                    end
                    default: begin
                        code_r = exgp_pkg::CODE_W'(7);
                        len_r  = exgp_pkg::LEN_W'(3);
                    end
                endcase
            end
            exgp_pkg::KIND_UNARY2: begin
                case (u_un2)
                    2'd0: begin
                        code_r = exgp_pkg::CODE_W'(0);
                        len_r  = exgp_pkg::LEN_W'(1);
                    end
                    2'd1: begin
                        code_r = exgp_pkg::CODE_W'(2);
                        len_r  = exgp_pkg::LEN_W'(2);
                    end
                    default: begin
                        code_r = exgp_pkg::CODE_W'(3);
                        len_r  = exgp_pkg::LEN_W'(2);
                    end
                endcase
            end
            exgp_pkg::KIND_RAW: begin
                code_r = exgp_pkg::CODE_W'(i_value) & raw_mask;
                len_r  = exgp_pkg::LEN_W'(raw_cnt);
            end
            exgp_pkg::KIND_FLUSH: begin
                flush_r = 1'b1;
            end
            default: begin
                code_r = '0;
            end
        endcase
    end

    // left align so the first stream bit sits in the top bit
    always_comb begin
        o_code.code  = code_r << (exgp_pkg::LEN_W'(exgp_pkg::CODE_W) - len_r);
        o_code.len   = len_r;
        o_code.flush = flush_r;
    end

endmodule

// File: src/exgp_fifo.sv
// short request queue between the encoder and the packer
module exgp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  exgp_pkg::t_code i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output exgp_pkg::t_code o_data
);

    exgp_pkg::t_code                r_mem [exgp_pkg::FIFO_DEPTH];
    logic [exgp_pkg::PTR_W-1:0]     r_wr_ptr;
    logic [exgp_pkg::PTR_W-1:0]     r_rd_ptr;
    logic [exgp_pkg::PTR_W:0]       r_count;
    logic [exgp_pkg::PTR_W-1:0]     n_wr_ptr;
    logic [exgp_pkg::PTR_W-1:0]     n_rd_ptr;
    logic [exgp_pkg::PTR_W:0]       n_count;

    // status
    assign o_full  = (r_count == (exgp_pkg::PTR_W + 1)'(exgp_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == exgp_pkg::PTR_W'(exgp_pkg::FIFO_DEPTH - 1))
                     ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == exgp_pkg::PTR_W'(exgp_pkg::FIFO_DEPTH - 1))
                     ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/exgp_packer.sv
// back end: merges codewords behind pending bits, a byte per unstalled cycle
module exgp_packer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  exgp_pkg::t_code             i_q_data,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [exgp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last
);

    logic [exgp_pkg::ACC_W-1:0]  r_acc;
    logic [exgp_pkg::LEN_W-1:0]  r_len;
    logic                        r_out_valid;
    logic [exgp_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_last;
    logic [exgp_pkg::ACC_W-1:0]  n_acc;
    logic [exgp_pkg::LEN_W-1:0]  n_len;

    logic                        out_free;
    logic                        emit;
    logic                        load;
    logic [exgp_pkg::ACC_W-1:0]  base_acc;
    logic [exgp_pkg::LEN_W-1:0]  base_len;
    logic [exgp_pkg::ACC_W-1:0]  code_w;
    logic [exgp_pkg::ACC_W-1:0]  merged_acc;
    logic [exgp_pkg::LEN_W-1:0]  merged_len;

    // byte emission and next codeword merge in the same cycle
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        emit     = (r_len >= exgp_pkg::LEN_W'(exgp_pkg::BYTE_W)) && out_free;
        base_acc = emit ? (r_acc << exgp_pkg::BYTE_W) : r_acc;
        base_len = emit ? (r_len - exgp_pkg::LEN_W'(exgp_pkg::BYTE_W)) : r_len;
        load     = i_q_valid && (base_len < exgp_pkg::LEN_W'(exgp_pkg::BYTE_W));

        code_w     = {i_q_data.code, exgp_pkg::BYTE_W'(0)};
        merged_acc = base_acc | (code_w >> base_len[exgp_pkg::PEND_W-1:0]);
        if (i_q_data.flush) begin
            merged_len = (base_len != '0) ? exgp_pkg::LEN_W'(exgp_pkg::BYTE_W) : '0;
        end else begin
            merged_len = base_len + i_q_data.len;
        end

        n_acc = load ? merged_acc : base_acc;
        n_len = load ? merged_len : base_len;
    end

    assign o_q_pop     = load;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

    // accumulator; pending bits start out cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_len <= '0;
        end else begin
            r_acc <= n_acc;
            r_len <= n_len;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= r_acc[exgp_pkg::ACC_W-1 -: exgp_pkg::BYTE_W];
            r_last     <= (r_len < exgp_pkg::LEN_W'(2 * exgp_pkg::BYTE_W));
        end
    end

endmodule

// File: src/exp_golomb_bit_packer_top.sv
// exp-golomb bit packer top level: encoder, request queue and byte packer
// path: with queue and packer idle, the first byte of a request passes through the queue,
//   the packer accumulator and the output register; the packer takes a new request only once
//   under a byte of bits is pending, as bytes drain through its single byte-wide output register
// reset: synchronous active low; clears the queue, pending bits and output valid
module exp_golomb_bit_packer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [exgp_pkg::KIND_W-1:0]  i_kind,
    input  logic [exgp_pkg::VALUE_W-1:0] i_value,
    input  logic [exgp_pkg::CNT_W-1:0]   i_bit_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [exgp_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_last
);

    exgp_pkg::t_code enc_code;
    exgp_pkg::t_code q_data;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;

    // unused kind is taken and dropped
    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full && (i_kind != exgp_pkg::KIND_UNUSED);

    exgp_encoder u_encoder (
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_code      (enc_code)
    );

    exgp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (enc_code),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    exgp_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// File: src/exgp_checker.sv
// port-level checks for the exp-golomb bit packer, bound to the top level
module exgp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [exgp_pkg::BYTE_W-1:0]  o_out_byte,
    input logic                         o_last
);

    // a stalled output byte holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output request changed");

    // reset empties the output register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset empties the request queue
    assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // a request into an empty design cannot produce a byte in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("byte appeared too early after reset");

endmodule

bind exp_golomb_bit_packer_top exgp_checker u_exgp_checker (.*);

// File: bench/tb.sv
// self-checking testbench for the exp-golomb bit packer: directed table, then random requests
`timescale 1ns / 1ps

module tb;
    import exgp_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 32;
    localparam int PHASE_ITEMS  = 107;
    localparam int SCRIPT_LEN   = 29;

    // one stimulus row; typed rows carry their bytes, first byte in want[39:32]
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   count;
        logic               typed;
        logic [2:0]         nbytes;
        logic [39:0]        want;
    } stim_row_t;

    // one stream byte owed by the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } stream_byte_t;

    localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
        '{KIND_FLUSH,    26'd0,         5'd0,  1'b1, 3'd0, 40'h0},
        '{KIND_RAW,      26'h00000A5,   5'd8,  1'b1, 3'd1, 40'hA5_00_00_00_00},
        '{KIND_RAW,      26'h3FFFFFF,   5'd31, 1'b1, 3'd3, 40'hFF_FF_FF_00_00},
        '{KIND_FLUSH,    26'd0,         5'd0,  1'b1, 3'd1, 40'h80_00_00_00_00},
        '{KIND_ESCAPE,   26'h1FFFFFE,   5'd0,  1'b1, 3'd4, 40'h00_3F_FF_FF_00},
        '{KIND_FLUSH,    26'd0,         5'd0,  1'b1, 3'd1, 40'hE0_00_00_00_00},
        '{KIND_UNSIGNED, 26'd0,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNSIGNED, 26'd2046,      5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNSIGNED, 26'd2047,      5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNSIGNED, 26'h3FFFFFF,   5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_SIGNED,   26'd0,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_SIGNED,   26'h3FFFFFF,   5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_SIGNED,   -26'd2046,     5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_SIGNED,   26'h2000000,   5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_SIGNED,   26'd2047,      5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_ESCAPE,   26'd1022,      5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_ESCAPE,   26'd1023,      5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_ESCAPE,   26'h1FFFFFF,   5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_ESCAPE,   -26'd5,        5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY3,   26'd0,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY3,   26'd1,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY3,   26'd2,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY3,   26'd9,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY2,   26'd0,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY2,   26'd1,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNARY2,   26'd5,         5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_RAW,      26'h15A5A5A,   5'd0,  1'b0, 3'd0, 40'h0},
        '{KIND_UNUSED,   26'h2AAAAAA,   5'd17, 1'b0, 3'd0, 40'h0},
        '{KIND_FLUSH,    26'd0,         5'd0,  1'b0, 3'd0, 40'h0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [VALUE_W-1:0]  i_value;
    logic [CNT_W-1:0]    i_bit_count;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_last;

    // bits waiting for their byte, as the block should hold them
    logic [6:0]          pend_bits;
    logic [2:0]          pend_cnt;
    logic [63:0]         code_acc;
    int                  code_len;
    logic [BYTE_W-1:0]   code_bytes[$];
    stream_byte_t        stream_q[$];

    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  mismatches;
    int                  quiet_cycles;

    exp_golomb_bit_packer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // append len bits, msb first
    function automatic void put_bits(input logic [63:0] bits, input int len);
        if (len > 0) begin
            code_acc = (code_acc << len) | (bits & ((64'd1 << len) - 64'd1));
            code_len += len;
        end
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // zero prefix, then value+1 in its significant bits
    function automatic void put_golomb(input longint v);
        logic [63:0] m;
        int          n;
        m = 64'(v + 1);
        n = 0;
        for (int i = 0; i < 40; i++) begin
            if (m[i]) begin
                n = i + 1;
            end
        end
        put_bits(64'd0, n - 1);
        put_bits(m, n);
    endfunction

    // encode one request on top of the waiting bits and cut out whole bytes
    function automatic void pack_request(input logic [KIND_W-1:0] kind,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [CNT_W-1:0] count);
        longint sv;
        longint mag;
        longint m;
        longint esc_hi;
        longint u;
        int     raw_n;
        sv = longint'(value);
        if (value[VALUE_W-1]) begin
            sv = sv - (longint'(1) << VALUE_W);
        end
        esc_hi = (ESCAPE_BITS > ESCAPE_PREFIX) ? (longint'(1) << ESCAPE_BITS) - 2
                                               : (longint'(1) << ESCAPE_PREFIX) - 2;
        code_bytes.delete();
        if (kind == KIND_UNUSED) begin
            return;
        end
        code_acc = 64'(pend_bits);
        code_len = int'(pend_cnt);
        case (kind)
            KIND_UNSIGNED: begin
                put_golomb(clamp(sv, 0, EG_MAX));
            end
            KIND_SIGNED: begin
                mag = clamp((sv < 0) ? -sv : sv, 0, EG_MAX);
                put_golomb(mag);
                if (mag != 0) begin
                    put_bits((sv < 0) ? 64'd1 : 64'd0, 1);
                end
            end
            KIND_ESCAPE: begin
                m = clamp(sv, 0, esc_hi) + 1;
                if (m < (longint'(1) << ESCAPE_PREFIX)) begin
                    put_golomb(m - 1);
                end else begin
                    put_bits(64'd0, ESCAPE_PREFIX);
                    put_bits(64'(m), ESCAPE_BITS);
                end
            end
            KIND_UNARY3: begin
                u = clamp(sv, 0, 3);
                if (u == 0) put_bits(64'd0, 1);
                else if (u == 1) put_bits(64'd2, 2);
                else if (u == 2) put_bits(64'd6, 3);
                else put_bits(64'd7, 3);
            end
            KIND_UNARY2: begin
                u = clamp(sv, 0, 2);
                if (u == 0) put_bits(64'd0, 1);
                else if (u == 1) put_bits(64'd2, 2);
                else put_bits(64'd3, 2);
            end
            KIND_RAW: begin
                raw_n = (int'(count) > RAW_MAX) ? RAW_MAX : int'(count);
                put_bits(64'(value), raw_n);
            end
            default: begin
                // flush pads the partial byte, nothing on a byte boundary
                if (code_len != 0) begin
                    put_bits(64'd0, 8 - code_len);
                end
            end
        endcase
        while (code_len >= 8) begin
            code_bytes.push_back(BYTE_W'(code_acc >> (code_len - 8)));
            code_len -= 8;
        end
        pend_cnt  = 3'(code_len);
        pend_bits = 7'(code_acc & ((64'd1 << code_len) - 64'd1));
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        int        pick;
        r = '0;
        r.kind = KIND_W'($urandom_range(0, 7));
        r.count = CNT_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: r.value = VALUE_W'($urandom_range(0, 40));
            4, 5: r.value = VALUE_W'($urandom_range(1010, 2060));
            6: r.value = VALUE_W'($urandom);
            7: r.value = VALUE_W'(0 - $urandom_range(1, 2060));
            default: r.value = VALUE_W'($urandom_range(33554400, 33554431));
        endcase
        return r;
    endfunction

    // drive one request until accepted, then record the bytes it owes
    task automatic drive_request(input stim_row_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= r.kind;
        i_value     <= r.value;
        i_bit_count <= r.count;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pack_request(r.kind, r.value, r.count);
        if (r.typed) begin
            code_bytes.delete();
            for (int i = 0; i < int'(r.nbytes); i++) begin
                code_bytes.push_back(r.want[39 - 8 * i -: 8]);
            end
        end
        foreach (code_bytes[i]) begin
            stream_q.push_back('{data: code_bytes[i], last: (i == code_bytes.size() - 1)});
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // output check and watchdog
    always @(posedge i_clk) begin
        stream_byte_t exp_b;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (stream_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              o_out_byte, o_last));
                end else begin
                    exp_b = stream_q.pop_front();
                    if (o_out_byte !== exp_b.data) begin
                        report_mismatch($sformatf("byte %02h, wanted %02h",
                                                  o_out_byte, exp_b.data));
                    end
                    if (o_last !== exp_b.last) begin
                        report_mismatch($sformatf("last %0b, wanted %0b on byte %02h",
                                                  o_last, exp_b.last, exp_b.data));
                    end
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("tb NOT OK");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_UNSIGNED;
        i_value       = '0;
        i_bit_count   = '0;
        pend_bits     = '0;
        pend_cnt      = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 30;
        recv_idle_pct = 47;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (SCRIPT[i]) begin
            drive_request(SCRIPT[i]);
        end

        // random requests under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 47 : 0;
            recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 30 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                drive_request(random_row());
            end
        end
        i_in_valid <= 1'b0;

        // drain
        while (stream_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/exgp_pkg.sv
src/exgp_encoder.sv
src/exgp_fifo.sv
src/exgp_packer.sv
src/exp_golomb_bit_packer_top.sv
src/exgp_checker.sv
bench/tb.sv
